>>> src/ppm_pkg.sv
// ppm_pkg: types and constants shared by the ppm p6 stream parser
// result word layout, result kinds, status codes, parse phases, character codes
// no dependencies
package ppm_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC      = 3'd0,
    PH_LINE_START = 3'd1,
    PH_COMMENT    = 3'd2,
    PH_WIDTH      = 3'd3,
    PH_HEIGHT     = 3'd4,
    PH_MAXVAL     = 3'd5,
    PH_PIXELS     = 3'd6,
    PH_IDLE       = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SIX  = 8'h36;

  localparam logic [3:0] MIN_FILE_LEN = 4'd10;
  localparam logic [3:0] MAGIC_POS    = 4'd1;
  localparam logic [3:0] HEADER_POS   = 4'd2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic [23:0] pixel_rgb;
    logic [31:0] pixel_index;
    logic [1:0]  status;
    logic        is_last;
  } result_t;

endpackage

>>> src/ppm_if.sv
// ppm_byte_if and ppm_result_if: valid/ready channels of the ppm p6 stream parser
// byte_if carries one file byte per word, result_if one parser result per word
// no dependencies
interface ppm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [15:0] max_value;
  logic [23:0] pixel_rgb;
  logic [31:0] pixel_index;
  logic [1:0]  status;
  logic        is_last;

  modport source (output valid, output result_kind, output image_width,
                  output image_height, output max_value, output pixel_rgb,
                  output pixel_index, output status, output is_last, input ready);
  modport sink (input valid, input result_kind, input image_width,
                input image_height, input max_value, input pixel_rgb,
                input pixel_index, input status, input is_last, output ready);
endinterface

>>> src/ppm_p6_stream_parser_top.sv
// ppm_p6_stream_parser_top: byte-serial parser for binary ppm (p6) image files
// depends on ppm_pkg and the channel interfaces in ppm_if.sv
//
// usage:
//   stream takes one file byte per word; last_byte marks the final byte of a file.
//   result gives a header word once maxval is parsed, one pixel word per complete
//   rgb triple up to width*height pixels, and one status word (is_last set) for
//   the final byte of the file. the next byte after the final one starts a new file.
//   throughput: one byte per cycle while stream.ready is high. a byte's results
//   are registered into the output queue when the byte is taken. the state update
//   of a byte is a single register stage; results go through a three-word output
//   queue. stream.ready is high while the queue holds at most one word, so a final
//   byte that yields both a pixel or header word and a status word always finds
//   room for both words; when result stalls, the queue fills and stream.ready
//   drops as soon as two words wait.
//   reset (rst, synchronous) empties the queue and returns the parser to the
//   magic check of a fresh file.
module ppm_p6_stream_parser_top #(
  parameter int DIM_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  ppm_byte_if.sink     stream,
  ppm_result_if.source result
);
  import ppm_pkg::*;

  localparam int AW = DIM_BITS + 4;
  localparam int PW = 2 * DIM_BITS;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

  phase_t                  phase, phase_next;
  logic [3:0]              byte_position, byte_position_next;
  logic [DIM_BITS-1:0]     acc, acc_next;
  logic [DIM_BITS-1:0]     stored_width, stored_width_next;
  logic [DIM_BITS-1:0]     stored_height, stored_height_next;
  logic [DIM_BITS-1:0]     stored_maxval, stored_maxval_next;
  logic [1:0]              triple_count, triple_count_next;
  logic [15:0]             partial_rgb, partial_rgb_next;
  logic [31:0]             pixel_count, pixel_count_next;
  logic                    magic_error, magic_error_next;
  logic [PW-1:0]           total_pixels;

  logic                    accept;
  phase_t                  ph;
  logic [AW-1:0]           digit_sum;
  logic [31:0]             pixel_count_inc;
  logic                    main_valid;
  logic [1:0]              main_kind;
  logic [23:0]             main_rgb;
  logic [31:0]             main_index;
  result_t                 main_res, status_res, r0, r1;
  logic [1:0]              push_n;

  result_t                 q [3];
  result_t                 q_next [3];
  result_t                 s [3];
  logic [1:0]              cnt, cnt_next, base;
  logic                    pop;

  assign accept       = stream.valid && stream.ready;
  assign stream.ready = (cnt <= 2'd1);
  assign pop          = (cnt != 2'd0) && result.ready;

  assign digit_sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                   + AW'(stream.data_byte - CH_ZERO);
  assign pixel_count_inc = pixel_count + 32'd1;
  assign total_pixels    = PW'(stored_width) * PW'(stored_height);

  // per-byte parse step
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    acc_next           = acc;
    stored_width_next  = stored_width;
    stored_height_next = stored_height;
    stored_maxval_next = stored_maxval;
    triple_count_next  = triple_count;
    partial_rgb_next   = partial_rgb;
    pixel_count_next   = pixel_count;
    magic_error_next   = magic_error;
    main_valid         = 1'b0;
    main_kind          = KIND_HEADER;
    main_rgb           = 24'd0;
    main_index         = 32'd0;

    if (byte_position < MIN_FILE_LEN) begin
      byte_position_next = byte_position + 4'd1;
    end

    ph = phase;
    if (phase == PH_LINE_START) begin
      ph = (stream.data_byte == CH_HASH) ? PH_COMMENT : PH_WIDTH;
    end
    phase_next = ph;

    case (ph)
      PH_MAGIC: begin
        if (byte_position == MAGIC_POS && stream.data_byte != CH_SIX) begin
          magic_error_next = 1'b1;
          phase_next       = PH_IDLE;
        end else if (byte_position >= HEADER_POS) begin
          phase_next = PH_LINE_START;
        end
      end
      PH_COMMENT: begin
        if (stream.data_byte == CH_LF) begin
          phase_next = PH_LINE_START;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (stream.data_byte inside {[CH_ZERO:CH_NINE]}) begin
          acc_next = (digit_sum > {4'b0, DIM_MAX}) ? DIM_MAX : digit_sum[DIM_BITS-1:0];
        end else begin
          acc_next = '0;
          if (ph == PH_WIDTH) begin
            stored_width_next = acc;
            phase_next        = PH_HEIGHT;
          end else if (ph == PH_HEIGHT) begin
            stored_height_next = acc;
            phase_next         = PH_MAXVAL;
          end else begin
            stored_maxval_next = acc;
            main_valid         = 1'b1;
            main_kind          = KIND_HEADER;
            phase_next         = (total_pixels == '0) ? PH_IDLE : PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        if (triple_count < 2'd2) begin
          partial_rgb_next  = {partial_rgb[7:0], stream.data_byte};
          triple_count_next = triple_count + 2'd1;
        end else begin
          main_valid        = 1'b1;
          main_kind         = KIND_PIXEL;
          main_rgb          = {partial_rgb, stream.data_byte};
          main_index        = pixel_count;
          pixel_count_next  = pixel_count_inc;
          triple_count_next = 2'd0;
          partial_rgb_next  = 16'd0;
          if (pixel_count_inc >= 32'(total_pixels)) begin
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    main_res.result_kind  = main_kind;
    main_res.image_width  = 16'(stored_width_next);
    main_res.image_height = 16'(stored_height_next);
    main_res.max_value    = 16'(stored_maxval_next);
    main_res.pixel_rgb    = main_rgb;
    main_res.pixel_index  = main_index;
    main_res.status       = ST_OK;
    main_res.is_last      = 1'b0;

    status_res             = main_res;
    status_res.result_kind = KIND_STATUS;
    status_res.pixel_rgb   = 24'd0;
    status_res.pixel_index = pixel_count_next;
    status_res.is_last     = 1'b1;
    if (byte_position_next < MIN_FILE_LEN) begin
      status_res.status = ST_SHORT;
    end else if (magic_error_next) begin
      status_res.status = ST_BAD_MAGIC;
    end else begin
      status_res.status = ST_OK;
    end

    r0     = main_valid ? main_res : status_res;
    r1     = status_res;
    push_n = {1'b0, main_valid} + {1'b0, stream.last_byte};
  end

  // output queue, head at entry 0
  always_comb begin
    s[0]     = pop ? q[1] : q[0];
    s[1]     = pop ? q[2] : q[1];
    s[2]     = q[2];
    base     = cnt - {1'b0, pop};
    cnt_next = accept ? base + push_n : base;
    for (int i = 0; i < 3; i++) begin
      if (accept && push_n != 2'd0 && 2'(i) == base) begin
        q_next[i] = r0;
      end else if (accept && push_n == 2'd2 && 2'(i) == base + 2'd1) begin
        q_next[i] = r1;
      end else begin
        q_next[i] = s[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q[i] <= q_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && stream.last_byte)) begin
      phase         <= PH_MAGIC;
      byte_position <= 4'd0;
      acc           <= '0;
      stored_width  <= '0;
      stored_height <= '0;
      stored_maxval <= '0;
      triple_count  <= 2'd0;
      partial_rgb   <= 16'd0;
      pixel_count   <= 32'd0;
      magic_error   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      acc           <= acc_next;
      stored_width  <= stored_width_next;
      stored_height <= stored_height_next;
      stored_maxval <= stored_maxval_next;
      triple_count  <= triple_count_next;
      partial_rgb   <= partial_rgb_next;
      pixel_count   <= pixel_count_next;
      magic_error   <= magic_error_next;
    end
  end

  assign result.valid        = (cnt != 2'd0);
  assign result.result_kind  = q[0].result_kind;
  assign result.image_width  = q[0].image_width;
  assign result.image_height = q[0].image_height;
  assign result.max_value    = q[0].max_value;
  assign result.pixel_rgb    = q[0].pixel_rgb;
  assign result.pixel_index  = q[0].pixel_index;
  assign result.status       = q[0].status;
  assign result.is_last      = q[0].is_last;

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && stream.last_byte |=> phase == PH_MAGIC && byte_position == 4'd0)
    else $error("parser did not restart after final byte");

  a_magic_idle: assert property (@(posedge clk) disable iff (rst)
    magic_error |-> phase == PH_IDLE)
    else $error("bad magic but parser not idle");

  a_triple_clear: assert property (@(posedge clk) disable iff (rst)
    phase != PH_PIXELS |-> triple_count == 2'd0 && partial_rgb == 16'd0)
    else $error("partial pixel held outside pixel phase");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    !(accept && stream.last_byte) |=> pixel_count >= $past(pixel_count))
    else $error("pixel count went backwards");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    accept |=> cnt != 2'd0 || !$past(stream.last_byte))
    else $error("status word lost");

endmodule
